// ===== src/assert_macros.svh =====
// assertion macros included by the top-level core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define C2I_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("c2i assertion failed");
`define C2I_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("c2i forbidden condition seen");
`else
`define C2I_ASSERT(lbl, clk, rst_n, prop)
`define C2I_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== src/c2i_pkg.sv =====
// ----------------------------------------------------------------------------
// c2i_pkg
// shared types and codes for the col2im accumulate, bias and relu core
// ----------------------------------------------------------------------------
package c2i_pkg;

    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_HEIGHT   = 32;
    localparam int DEF_MAX_WIDTH    = 32;

    // op codes
    localparam logic [1:0] OP_ACC  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_BIAS = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_KERNEL   = 3'd3;
    localparam logic [2:0] REG_STRIDE   = 3'd4;
    localparam logic [2:0] REG_PAD      = 3'd5;
    localparam logic [2:0] REG_DILATION = 3'd6;
    localparam logic [2:0] REG_POST     = 3'd7;

    // controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic clr_step;
        logic dim_init;
        logic dim_step;
        logic acc_pos;
        logic acc_addr;
        logic acc_rd;
        logic acc_wr;
        logic ro_step;
        logic ro_rd;
        logic ro_out;
    } dp_cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic clr_done;
        logic dim_done;
        logic ro_ch_found;
    } dp_status_t;

endpackage

// ===== src/col2im_accumulate_bias_relu_core.sv =====
// ----------------------------------------------------------------------------
// col2im_accumulate_bias_relu_core
// col2im scatter-accumulate into an image store, drained with bias and relu
//
//   channel   handshake              payload
//   input     start / busy           op, value, bias_channel
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//   result    strobe (one cycle)     pixel, last
//
// accumulate: busy through the position, address, memory read and write states
// read-out: busy through the channel search (subtracting the plane size once a
//   cycle), the memory read and the output state; strobe follows the busy window
// bias load and unused op: busy stays low
// reset: clearing pass over all MAX_CHANNELS*MAX_HEIGHT*MAX_WIDTH words, then the
//   output size division; every config write also re-runs that division
// results are never stalled; the receiver takes each one in its strobe cycle
// ----------------------------------------------------------------------------
module col2im_accumulate_bias_relu_core #(
    parameter int MAX_CHANNELS = c2i_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = c2i_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = c2i_pkg::DEF_MAX_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [31:0] value,
    input  logic [3:0]         bias_channel,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               strobe,
    output logic signed [31:0] pixel,
    output logic               last
);
    import c2i_pkg::*;

`include "assert_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    c2i_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .cfg_valid (cfg_valid),
        .status    (status),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // datapath
    c2i_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .value        (value),
        .bias_channel (bias_channel),
        .strobe       (strobe),
        .pixel        (pixel),
        .last         (last)
    );

    // checks
    `C2I_ASSERT(a_strobe_single, clk, rst_n, strobe |=> !strobe)
    `C2I_ASSERT(a_strobe_idle, clk, rst_n, strobe |-> !busy)
    `C2I_ASSERT(a_cfg_redim, clk, rst_n, (cfg_valid && cfg_ready) |=> busy)
    `C2I_NEVER(a_cmd_overlap, clk, rst_n, cmd.acc_wr && cmd.ro_out)

endmodule

// ===== src/c2i_ctrl.sv =====
// ----------------------------------------------------------------------------
// c2i_ctrl
// sequencer: clearing pass, output size division, per-op step control
// ----------------------------------------------------------------------------
module c2i_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           op,
    input  logic                 cfg_valid,
    input  c2i_pkg::dp_status_t  status,
    output logic                 busy,
    output logic                 cfg_ready,
    output c2i_pkg::dp_cmd_t     cmd
);
    import c2i_pkg::*;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_DIM_INIT = 4'd1;
    localparam logic [3:0] ST_DIM_RUN  = 4'd2;
    localparam logic [3:0] ST_IDLE     = 4'd3;
    localparam logic [3:0] ST_ACC_POS  = 4'd4;
    localparam logic [3:0] ST_ACC_ADDR = 4'd5;
    localparam logic [3:0] ST_ACC_RD   = 4'd6;
    localparam logic [3:0] ST_ACC_WR   = 4'd7;
    localparam logic [3:0] ST_RO_CH    = 4'd8;
    localparam logic [3:0] ST_RO_RD    = 4'd9;
    localparam logic [3:0] ST_RO_OUT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;
    logic       cfg_fire;

    // an item transfer wins over a config write in the same cycle
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = ((state_reg == ST_IDLE) && !start) || (state_reg == ST_CLEAR);
    assign accept    = start && !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.in_load = accept;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_DIM_INIT;
                end
            end
            ST_DIM_INIT:
            begin
                cmd.dim_init = 1'b1;
                state_next   = ST_DIM_RUN;
            end
            ST_DIM_RUN:
            begin
                cmd.dim_step = 1'b1;
                if (status.dim_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    state_next = ST_DIM_INIT;
                end
                else if (accept)
                begin
                    priority case (op)
                        OP_ACC:  state_next = ST_ACC_POS;
                        OP_READ: state_next = ST_RO_CH;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC_POS:
            begin
                cmd.acc_pos = 1'b1;
                state_next  = ST_ACC_ADDR;
            end
            ST_ACC_ADDR:
            begin
                cmd.acc_addr = 1'b1;
                state_next   = ST_ACC_RD;
            end
            ST_ACC_RD:
            begin
                cmd.acc_rd = 1'b1;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RO_CH:
            begin
                if (status.ro_ch_found)
                begin
                    state_next = ST_RO_RD;
                end
                else
                begin
                    cmd.ro_step = 1'b1;
                end
            end
            ST_RO_RD:
            begin
                cmd.ro_rd  = 1'b1;
                state_next = ST_RO_OUT;
            end
            ST_RO_OUT:
            begin
                cmd.ro_out = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/c2i_dp.sv =====
// ----------------------------------------------------------------------------
// c2i_dp
// datapath: config registers, scatter counters, image and bias memories,
// output size dividers, read-out with bias and relu
// ----------------------------------------------------------------------------
module c2i_dp #(
    parameter int MAX_CHANNELS = c2i_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = c2i_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = c2i_pkg::DEF_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c2i_pkg::dp_cmd_t     cmd,
    output c2i_pkg::dp_status_t  status,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [1:0]           op,
    input  logic signed [31:0]   value,
    input  logic [3:0]           bias_channel,
    output logic                 strobe,
    output logic signed [31:0]   pixel,
    output logic                 last
);
    import c2i_pkg::*;

    localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int PL_W  = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
    localparam int NC_W  = $clog2(MAX_CHANNELS + 1);
    localparam int NH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int NW_W  = $clog2(MAX_WIDTH + 1);
    localparam int RI_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CI_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CHI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int MAXD  = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int DW    = $clog2(MAXD + 32);
    localparam int SW    = (DW + 1 > 9) ? DW + 1 : 9;
    localparam int RW    = DW + 6;
    localparam int DC_W  = $clog2(DW + 1);

    // zero nibble acts as one
    function automatic logic [3:0] nib_min1(input logic [3:0] v);
        nib_min1 = (v == 4'd0) ? 4'd1 : v;
    endfunction

    // one restoring division step, remainder in the upper four bits
    function automatic logic [DW+3:0] div_step(input logic [3:0] r,
                                               input logic [DW-1:0] q,
                                               input logic [3:0] d);
        logic [4:0] sr;
        sr = {r, q[DW-1]};
        if (sr >= {1'b0, d})
        begin
            div_step = {4'(sr - {1'b0, d}), q[DW-2:0], 1'b1};
        end
        else
        begin
            div_step = {sr[3:0], q[DW-2:0], 1'b0};
        end
    endfunction

    // configuration registers
    logic [4:0] channels_reg;
    logic [5:0] height_reg;
    logic [5:0] width_reg;
    logic [7:0] kernel_reg;
    logic [7:0] stride_reg;
    logic [7:0] pad_reg;
    logic [7:0] dil_reg;
    logic [1:0] post_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= 5'd1;
            height_reg   <= 6'd1;
            width_reg    <= 6'd1;
            kernel_reg   <= 8'h11;
            stride_reg   <= 8'h11;
            pad_reg      <= 8'h00;
            dil_reg      <= 8'h11;
            post_reg     <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNELS: channels_reg <= cfg_data[4:0];
                REG_HEIGHT:   height_reg   <= cfg_data[5:0];
                REG_WIDTH:    width_reg    <= cfg_data[5:0];
                REG_KERNEL:   kernel_reg   <= cfg_data;
                REG_STRIDE:   stride_reg   <= cfg_data;
                REG_PAD:      pad_reg      <= cfg_data;
                REG_DILATION: dil_reg      <= cfg_data;
                REG_POST:     post_reg     <= cfg_data[1:0];
            endcase
        end
    end

    // effective sizes
    logic [NC_W-1:0] nc;
    logic [NH_W-1:0] nh;
    logic [NW_W-1:0] nw;
    logic [3:0]      kh, kw, sh, sw, dh, dw, ph, pw;

    always_comb
    begin
        if (channels_reg == 5'd0)
            nc = NC_W'(1);
        else if (32'(channels_reg) > 32'(MAX_CHANNELS))
            nc = NC_W'(MAX_CHANNELS);
        else
            nc = NC_W'(channels_reg);
        if (height_reg == 6'd0)
            nh = NH_W'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            nh = NH_W'(MAX_HEIGHT);
        else
            nh = NH_W'(height_reg);
        if (width_reg == 6'd0)
            nw = NW_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            nw = NW_W'(MAX_WIDTH);
        else
            nw = NW_W'(width_reg);
    end

    assign kh = nib_min1(kernel_reg[7:4]);
    assign kw = nib_min1(kernel_reg[3:0]);
    assign sh = nib_min1(stride_reg[7:4]);
    assign sw = nib_min1(stride_reg[3:0]);
    assign dh = nib_min1(dil_reg[7:4]);
    assign dw = nib_min1(dil_reg[3:0]);
    assign ph = pad_reg[7:4];
    assign pw = pad_reg[3:0];

    // output size: span setup, then shared-step restoring division
    logic [SW-1:0]   span_v, span_h;
    logic [3:0]      rem_v_reg, rem_h_reg;
    logic [DW-1:0]   quo_v_reg, quo_h_reg;
    logic            neg_v_reg, neg_h_reg;
    logic [DC_W-1:0] dim_cnt_reg;
    logic [PL_W-1:0] plane_reg;
    logic [TW-1:0]   total_reg;
    logic [DW-1:0]   oh, ow;
    logic [DW+3:0]   step_v, step_h;

    assign span_v = SW'(nh) + SW'({ph, 1'b0}) - SW'(dh * (kh - 4'd1)) - SW'(1);
    assign span_h = SW'(nw) + SW'({pw, 1'b0}) - SW'(dw * (kw - 4'd1)) - SW'(1);
    assign step_v = div_step(rem_v_reg, quo_v_reg, sh);
    assign step_h = div_step(rem_h_reg, quo_h_reg, sw);
    assign oh = neg_v_reg ? DW'(1) : quo_v_reg + DW'(1);
    assign ow = neg_h_reg ? DW'(1) : quo_h_reg + DW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cnt_reg <= '0;
        end
        else if (cmd.dim_init)
        begin
            dim_cnt_reg <= DC_W'(DW);
        end
        else if (cmd.dim_step)
        begin
            dim_cnt_reg <= dim_cnt_reg - DC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dim_init)
        begin
            neg_v_reg <= span_v[SW-1];
            neg_h_reg <= span_h[SW-1];
            quo_v_reg <= DW'(span_v);
            quo_h_reg <= DW'(span_h);
            rem_v_reg <= 4'd0;
            rem_h_reg <= 4'd0;
            plane_reg <= PL_W'(nh * nw);
        end
        else if (cmd.dim_step)
        begin
            rem_v_reg <= step_v[DW+3:DW];
            quo_v_reg <= step_v[DW-1:0];
            rem_h_reg <= step_h[DW+3:DW];
            quo_h_reg <= step_h[DW-1:0];
            total_reg <= TW'(TW'(nc) * TW'(plane_reg));
        end
    end

    // clearing pass counter
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // input item latch and bias load
    logic signed [31:0] val_reg;
    logic [31:0]        bias_mem [MAX_CHANNELS];

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            val_reg <= value;
        end
        if (cmd.in_load && (op == OP_BIAS) && (32'(bias_channel) < 32'(MAX_CHANNELS)))
        begin
            bias_mem[CHI_W'(bias_channel)] <= value;
        end
    end

    // scatter counters
    logic [NC_W-1:0] chan_reg;
    logic [3:0]      krow_reg, kcol_reg;
    logic [DW-1:0]   orow_reg, ocol_reg;
    logic            wrap_oc, wrap_or, wrap_kc, wrap_kr, wrap_ch;

    assign wrap_oc = ({1'b0, ocol_reg} + (DW+1)'(1)) >= {1'b0, ow};
    assign wrap_or = ({1'b0, orow_reg} + (DW+1)'(1)) >= {1'b0, oh};
    assign wrap_kc = ({1'b0, kcol_reg} + 5'd1) >= {1'b0, kw};
    assign wrap_kr = ({1'b0, krow_reg} + 5'd1) >= {1'b0, kh};
    assign wrap_ch = ({1'b0, chan_reg} + (NC_W+1)'(1)) >= {1'b0, nc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= '0;
            krow_reg <= '0;
            kcol_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
        end
        else if (cmd.acc_wr)
        begin
            ocol_reg <= wrap_oc ? '0 : ocol_reg + DW'(1);
            if (wrap_oc)
            begin
                orow_reg <= wrap_or ? '0 : orow_reg + DW'(1);
                if (wrap_or)
                begin
                    kcol_reg <= wrap_kc ? '0 : kcol_reg + 4'd1;
                    if (wrap_kc)
                    begin
                        krow_reg <= wrap_kr ? '0 : krow_reg + 4'd1;
                        if (wrap_kr)
                        begin
                            chan_reg <= wrap_ch ? '0 : chan_reg + NC_W'(1);
                        end
                    end
                end
            end
        end
    end

    // image position and address
    logic [RW-1:0]   row_s, col_s;
    logic            in_img;
    logic [RI_W-1:0] row_reg;
    logic [CI_W-1:0] col_reg;
    logic            in_img_reg;
    logic [AW-1:0]   acc_addr_reg;

    assign row_s = RW'(krow_reg) * RW'(dh) + RW'(orow_reg) * RW'(sh) - RW'(ph);
    assign col_s = RW'(kcol_reg) * RW'(dw) + RW'(ocol_reg) * RW'(sw) - RW'(pw);
    assign in_img = !row_s[RW-1] && (row_s < RW'(nh)) &&
                    !col_s[RW-1] && (col_s < RW'(nw));

    always_ff @(posedge clk)
    begin
        if (cmd.acc_pos)
        begin
            row_reg    <= RI_W'(row_s);
            col_reg    <= CI_W'(col_s);
            in_img_reg <= in_img;
        end
        if (cmd.acc_addr)
        begin
            acc_addr_reg <= AW'(TW'(chan_reg) * TW'(plane_reg) +
                                TW'(row_reg) * TW'(nw) + TW'(col_reg));
        end
    end

    // read-out channel search by repeated subtraction
    logic [AW-1:0]   ro_idx_reg;
    logic [AW-1:0]   ro_rem_reg;
    logic [NC_W-1:0] ro_ch_reg;
    logic            ro_bias_ok;
    logic            ro_last;

    assign status.ro_ch_found = (TW'(ro_rem_reg) < TW'(plane_reg)) ||
                                (ro_ch_reg == NC_W'(MAX_CHANNELS));
    assign ro_bias_ok = post_reg[0] && (32'(ro_ch_reg) < 32'(MAX_CHANNELS));
    assign ro_last = (TW'(ro_idx_reg) + TW'(1)) >= total_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            ro_rem_reg <= ro_idx_reg;
            ro_ch_reg  <= '0;
        end
        else if (cmd.ro_step)
        begin
            ro_rem_reg <= ro_rem_reg - AW'(plane_reg);
            ro_ch_reg  <= ro_ch_reg + NC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ro_idx_reg <= '0;
        end
        else if (cmd.ro_out)
        begin
            ro_idx_reg <= ro_last ? '0 : ro_idx_reg + AW'(1);
        end
    end

    // image memory, one write and one registered read port
    logic [31:0]   img_mem [DEPTH];
    logic [31:0]   img_rd_reg;
    logic [31:0]   bias_rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ro_idx_reg;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (cmd.acc_wr)
        begin
            mem_we    = in_img_reg;
            mem_waddr = acc_addr_reg;
            mem_wdata = img_rd_reg + val_reg;
        end
        else if (cmd.ro_out)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            img_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.acc_rd)
        begin
            img_rd_reg <= img_mem[acc_addr_reg];
        end
        else if (cmd.ro_rd)
        begin
            img_rd_reg <= img_mem[ro_idx_reg];
        end
        if (cmd.ro_rd)
        begin
            bias_rd_reg <= bias_mem[CHI_W'(ro_ch_reg)];
        end
    end

    // bias, relu and output register
    logic [31:0] px_sum;
    logic [31:0] px_fin;

    assign px_sum = img_rd_reg + (ro_bias_ok ? bias_rd_reg : 32'd0);
    assign px_fin = (post_reg[1] && px_sum[31]) ? 32'd0 : px_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe <= 1'b0;
        end
        else
        begin
            strobe <= cmd.ro_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ro_out)
        begin
            pixel <= px_fin;
            last  <= ro_last;
        end
    end

    assign status.clr_done = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.dim_done = (dim_cnt_reg == DC_W'(1));

endmodule
